[rtl/core/graph_radius_diameter_bfs_defines.svh]
// Assertion macros shared by the graph radius/diameter RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef GRAPH_RADIUS_DIAMETER_BFS_DEFINES_SVH
`define GRAPH_RADIUS_DIAMETER_BFS_DEFINES_SVH

// Property checked on every rising clock edge once reset is released.
`define GRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge once reset is released.
`define GRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/grd_pkg.sv]
// Package for the graph radius/diameter block: request types, constants, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package grd_pkg;

  localparam int MaxVerticesDefault = 16;
  localparam int IdxW    = 4;
  localparam int WeightW = 4;
  localparam int CountW  = 5;
  localparam int DistW   = 8;

  localparam logic [CountW-1:0] VertexCountReset = CountW'(16);
  localparam logic [DistW-1:0]  DistMax          = 8'd255;

  typedef struct packed {
    logic [IdxW-1:0]    row_index;
    logic [IdxW-1:0]    column_index;
    logic [WeightW-1:0] edge_weight;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic [DistW-1:0] radius;
    logic [DistW-1:0] diameter;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StPop,
    StFetch,
    StScan,
    StFinish
  } state_e;

endpackage

`default_nettype wire

[rtl/core/grd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module grd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/graph_radius_diameter_bfs.sv]
// Search: a last entry starts a BFS from each active vertex in turn; each dequeued vertex has
//   its matrix row read through the adjacency RAM read port (one edge per cycle), and the
//   result is published after the last source.
// Throughput: one entry per cycle while loading; no request is taken during a search.
// Reset: async active low; FSM idle, vertex_count = 16, result slot empty. Matrix and queue
//   RAMs are not cleared; reading an unwritten matrix entry gives undefined results.
`timescale 1ns / 1ps
`default_nettype none

`include "graph_radius_diameter_bfs_defines.svh"

module graph_radius_diameter_bfs import grd_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // matrix entry requests
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_item_t          in_data_i,
  // result requests
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_item_t              out_data_o,
  // vertex_count register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i
);

  localparam int VW = $clog2(MAX_VERTICES);                  // vertex index
  localparam int CW = $clog2(MAX_VERTICES + 1);              // count up to MAX_VERTICES
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);   // adjacency address
  localparam int QW = VW + DistW;                            // queue entry {vertex, dist}

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CountW-1:0]   vcount_q, vcount_d;
  logic [VW-1:0]       src_q, src_d;          // current BFS source
  logic [CW-1:0]       head_q, head_d;        // queue read pointer
  logic [CW-1:0]       tail_q, tail_d;        // queue write pointer
  logic [CW-1:0]       scan_v_q, scan_v_d;    // next neighbor to fetch
  logic                pend_q, pend_d;        // adjacency read in flight
  logic [VW-1:0]       pend_v_q, pend_v_d;    // neighbor of that read
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic                out_valid_q, out_valid_d;

  // payload, no reset
  logic [VW-1:0]       cur_q, cur_d;          // vertex being expanded
  logic [DistW-1:0]    cur_dist_q, cur_dist_d;
  logic [DistW-1:0]    ecc_q, ecc_d;
  logic [DistW-1:0]    radius_q, radius_d;
  logic [DistW-1:0]    diam_q, diam_d;
  out_item_t           out_q, out_d;

  // ---------------------------------------------------------------------------
  // Memories: adjacency matrix and BFS queue (queue carries the distance too)
  // ---------------------------------------------------------------------------
  logic               adj_we;
  logic [AW-1:0]      adj_waddr;
  logic [AW-1:0]      adj_raddr;
  logic [WeightW-1:0] adj_rdata;

  logic               q_we;
  logic [VW-1:0]      q_waddr;
  logic [QW-1:0]      q_wdata;
  logic [QW-1:0]      q_rdata;

  grd_ram #(
    .WIDTH (WeightW),
    .DEPTH (MAX_VERTICES * MAX_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (in_data_i.edge_weight),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  grd_ram #(
    .WIDTH (QW),
    .DEPTH (MAX_VERTICES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (q_rdata)
  );

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          in_store;
  logic [CW-1:0] n_act;        // vertex_count clamped to 1..MAX_VERTICES
  logic          q_empty;
  logic          src_last;
  logic          scan_issue;
  logic          scan_done;
  logic          hit;          // pending neighbor gets discovered
  logic [DistW:0] dist_sum;
  logic [DistW-1:0] dist_new;
  logic          out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_store = (8'(in_data_i.row_index) < 8'(MAX_VERTICES))
                 && (8'(in_data_i.column_index) < 8'(MAX_VERTICES));

  always_comb begin
    if (vcount_q == '0) begin
      n_act = CW'(1);
    end else if (8'(vcount_q) > 8'(MAX_VERTICES)) begin
      n_act = CW'(MAX_VERTICES);
    end else begin
      n_act = CW'(vcount_q);
    end
  end

  assign q_empty    = !(head_q < tail_q);
  assign src_last   = (CW'(src_q) + CW'(1)) == n_act;
  assign scan_issue = scan_v_q < n_act;
  assign scan_done  = !scan_issue && !pend_q;

  assign hit = (state_q == StScan) && pend_q && (adj_rdata != '0)
            && !visited_q[pend_v_q] && (tail_q < CW'(MAX_VERTICES));

  // parent distance plus edge weight, saturating
  assign dist_sum = (DistW + 1)'(cur_dist_q) + (DistW + 1)'(adj_rdata);
  assign dist_new = (dist_sum > (DistW + 1)'(DistMax)) ? DistMax : dist_sum[DistW-1:0];

  // result slot can be loaded when empty or drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.last_entry) begin
          state_d = StInit;
        end
      end
      StInit: state_d = StPop;
      StPop: begin
        if (!q_empty) begin
          state_d = StFetch;
        end else if (src_last) begin
          state_d = StFinish;
        end else begin
          state_d = StInit;
        end
      end
      StFetch: state_d = StScan;
      StScan: begin
        if (scan_done) begin
          state_d = StPop;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memory controls and handshake outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = AW'(int'(in_data_i.row_index) * MAX_VERTICES + int'(in_data_i.column_index));
    adj_raddr = AW'(int'(cur_q) * MAX_VERTICES + int'(scan_v_q));
    q_we      = 1'b0;
    q_waddr   = tail_q[VW-1:0];
    q_wdata   = {pend_v_q, dist_new};
    case (state_q)
      StIdle: begin
        adj_we = in_acc && in_store;
      end
      StInit: begin
        // seed queue with the source at distance zero
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = {src_q, {DistW{1'b0}}};
      end
      StScan: begin
        q_we = hit;
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    vcount_d    = vcount_q;
    src_d       = src_q;
    head_d      = head_q;
    tail_d      = tail_q;
    scan_v_d    = scan_v_q;
    pend_d      = 1'b0;
    pend_v_d    = pend_v_q;
    visited_d   = visited_q;
    out_valid_d = out_valid_q;
    cur_d       = cur_q;
    cur_dist_d  = cur_dist_q;
    ecc_d       = ecc_q;
    radius_d    = radius_q;
    diam_d      = diam_q;
    out_d       = out_q;

    if (cfg_valid_i && cfg_ready_o) begin
      vcount_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.last_entry) begin
          src_d    = '0;
          radius_d = DistMax;
          diam_d   = '0;
        end
      end
      StInit: begin
        visited_d         = '0;
        visited_d[src_q]  = 1'b1;
        head_d            = '0;
        tail_d            = CW'(1);
        ecc_d             = '0;
      end
      StPop: begin
        if (!q_empty) begin
          head_d = head_q + CW'(1);
        end else begin
          // source finished: fold its eccentricity in
          if (ecc_q < radius_q) begin
            radius_d = ecc_q;
          end
          if (ecc_q > diam_q) begin
            diam_d = ecc_q;
          end
          if (!src_last) begin
            src_d = src_q + VW'(1);
          end
        end
      end
      StFetch: begin
        cur_d      = q_rdata[QW-1 -: VW];
        cur_dist_d = q_rdata[DistW-1:0];
        scan_v_d   = '0;
      end
      StScan: begin
        if (scan_issue) begin
          scan_v_d = scan_v_q + CW'(1);
          pend_d   = 1'b1;
          pend_v_d = scan_v_q[VW-1:0];
        end
        if (hit) begin
          visited_d[pend_v_q] = 1'b1;
          tail_d              = tail_q + CW'(1);
          if (dist_new > ecc_q) begin
            ecc_d = dist_new;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.radius    = radius_q;
          out_d.diameter  = diam_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcount_q    <= VertexCountReset;
      src_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      scan_v_q    <= '0;
      pend_q      <= 1'b0;
      pend_v_q    <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      src_q       <= src_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      scan_v_q    <= scan_v_d;
      pend_q      <= pend_d;
      pend_v_q    <= pend_v_d;
      visited_q   <= visited_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cur_dist_q <= cur_dist_d;
    ecc_q      <= ecc_d;
    radius_q   <= radius_d;
    diam_q     <= diam_d;
    out_q      <= out_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GRD_ASSERT(a_head_le_tail, head_q <= tail_q, "queue read pointer passed write pointer")
  `GRD_ASSERT_IMP(a_tail_le_n, state_q == StPop || state_q == StFetch || state_q == StScan,
    tail_q <= n_act, "more vertices queued than active")
  `GRD_ASSERT_IMP(a_visited_cnt, state_q == StPop || state_q == StFetch || state_q == StScan,
    $countones(visited_q) == int'(tail_q), "visited marks disagree with queue fill")
  `GRD_ASSERT_IMP(a_pend_range, state_q == StScan && pend_q, CW'(pend_v_q) < n_act,
    "neighbor fetched beyond active vertices")
  `GRD_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q) == StFinish,
    "result published outside finish state")

endmodule

`default_nettype wire

[test/tb_graph_radius_diameter_bfs.sv]
// Testbench for graph_radius_diameter_bfs: matrix entry requests in, radius/diameter results out.
// Predicts every result with its own BFS over a shadow matrix; depends on grd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import grd_pkg::*;

  localparam int MaxV       = MaxVerticesDefault;
  localparam int QuietLimit = 60000;
  localparam int IdleGuard  = 8;
  localparam int EndDrain   = 40;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CountW-1:0]   cfg_data  = '0;

  // request queue feeding the driver, and results still owed by the block
  in_item_t  pending_entries[$];
  out_item_t expected_extents[$];

  // shadow of the block's matrix and vertex_count register
  logic [WeightW-1:0] shadow_adj [MaxV*MaxV];
  logic [CountW-1:0]  shadow_count = VertexCountReset;
  // entries already queued for writing; keeps a search off unwritten cells
  bit                 loaded [MaxV*MaxV];

  int pushed_entries   = 0;
  int accepted_entries = 0;
  int quiet_cycles     = 0;
  int failures         = 0;
  int send_gap_pct     = 0;
  int recv_gap_pct     = 0;

  graph_radius_diameter_bfs u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // BFS from every active vertex in index order; a vertex's distance is taken from the
  // vertex that first found it (tree distance, not shortest path). Unreached vertices
  // do not count toward a source's eccentricity.
  function automatic out_item_t predict_extent();
    logic [IdxW-1:0] fifo [MaxV];
    bit              seen [MaxV];
    int              dist_of [MaxV];
    int              head, tail, cur, ecc, d, n, radius, diameter;
    out_item_t       res;
    n = (shadow_count == 0) ? 1 : ((shadow_count > MaxV) ? MaxV : int'(shadow_count));
    radius   = DistMax;
    diameter = 0;
    for (int s = 0; s < n; s++) begin
      foreach (seen[i]) seen[i] = 1'b0;
      head       = 0;
      tail       = 0;
      ecc        = 0;
      dist_of[s] = 0;
      seen[s]    = 1'b1;
      fifo[tail] = IdxW'(s);
      tail++;
      while (head < tail) begin
        cur = fifo[head];
        head++;
        for (int v = 0; v < n; v++) begin
          if (shadow_adj[cur*MaxV + v] != 0 && !seen[v] && tail < MaxV) begin
            d = dist_of[cur] + shadow_adj[cur*MaxV + v];
            if (d > DistMax) d = DistMax;
            seen[v]    = 1'b1;
            dist_of[v] = d;
            fifo[tail] = IdxW'(v);
            tail++;
            if (d > ecc) ecc = d;
          end
        end
      end
      if (ecc < radius) radius = ecc;
      if (ecc > diameter) diameter = ecc;
    end
    res.radius   = DistW'(radius);
    res.diameter = DistW'(diameter);
    return res;
  endfunction

  // Driver: presents the next request once the current one is taken; valid holds while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_entries.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_data  <= pending_entries.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // Monitor: tracks accepted config and entry requests, predicts, checks results.
  always @(posedge clk) begin
    logic      progress;
    out_item_t want;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        shadow_count = cfg_data;
        progress     = 1'b1;
      end
      if (in_valid && !in_stall) begin
        shadow_adj[{in_data.row_index, in_data.column_index}] = in_data.edge_weight;
        accepted_entries++;
        if (in_data.last_entry) expected_extents.push_back(predict_extent());
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (expected_extents.size() == 0) begin
          $error("result with nothing expected: radius %0d diameter %0d",
                 out_data.radius, out_data.diameter);
          failures++;
        end else begin
          want = expected_extents.pop_front();
          if (out_data.radius !== want.radius) begin
            $error("radius: expected %0d, got %0d", want.radius, out_data.radius);
            failures++;
          end
          if (out_data.diameter !== want.diameter) begin
            $error("diameter: expected %0d, got %0d", want.diameter, out_data.diameter);
            failures++;
          end
        end
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted request.
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_entry(int row, int col, int weight, bit last);
    in_item_t it;
    it.row_index    = IdxW'(row);
    it.column_index = IdxW'(col);
    it.edge_weight  = WeightW'(weight);
    it.last_entry   = last;
    loaded[row*MaxV + col] = 1'b1;
    pending_entries.push_back(it);
    pushed_entries++;
  endtask

  // Block idle: every request taken, every result back, plus a short guard.
  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_entries != pushed_entries || expected_extents.size() != 0);
    repeat (IdleGuard) @(posedge clk);
  endtask

  task automatic set_count(int value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CountW'(value);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_weight(int density);
    return ($urandom_range(0, 99) < density) ? $urandom_range(1, WeightW'('1)) : 0;
  endfunction

  // One graph over n vertices: a full shuffled load of the n x n block, or, once the
  // block is loaded, a few rewrites (some outside the active block) before the last entry.
  task automatic push_graph(int n);
    int  order[$];
    int  density, cnt, j, tmp, r, c;
    bit  covered;
    covered = 1'b1;
    for (int i = 0; i < n*n; i++) begin
      if (!loaded[(i / n)*MaxV + (i % n)]) covered = 1'b0;
    end
    density = $urandom_range(5, 95);
    if (covered && (n >= 10 || $urandom_range(0, 1) == 1)) begin
      cnt = $urandom_range(0, n);
      for (int i = 0; i < cnt; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          r = $urandom_range(0, MaxV-1);
          c = $urandom_range(0, MaxV-1);
        end else begin
          r = $urandom_range(0, n-1);
          c = $urandom_range(0, n-1);
        end
        push_entry(r, c, rand_weight(density), 1'b0);
      end
      // block already loaded, so the last entry may land anywhere
      push_entry($urandom_range(0, MaxV-1), $urandom_range(0, MaxV-1),
                 rand_weight(density), 1'b1);
    end else begin
      for (int i = 0; i < n*n; i++) order.push_back(i);
      for (int i = n*n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < n*n; i++) begin
        push_entry(order[i] / n, order[i] % n, rand_weight(density), i == n*n - 1);
      end
    end
  endtask

  task automatic run_phase(int count_value, int sets);
    int n;
    set_count(count_value);
    n = (count_value == 0) ? 1 : ((count_value > MaxV) ? MaxV : count_value);
    for (int i = 0; i < sets; i++) begin
      push_graph(n);
      // sender holds off mid-phase until every owed result is back
      if (i == sets / 2) wait_idle();
    end
  endtask

  initial begin
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_gap_pct = 11;
    recv_gap_pct = 45;

    // directed: single vertex with a self loop, then an unloop
    set_count(1);
    push_entry(0, 0, 15, 1'b1);
    push_entry(15, 15, 15, 1'b0);   // far corner, plain entry gives no result
    push_entry(15, 0, 0, 1'b0);
    push_entry(0, 0, 0, 1'b1);
    // count of zero behaves as one vertex
    set_count(0);
    push_entry(0, 0, 7, 1'b1);
    // two vertices, one-way heaviest edge: a source that reaches nothing
    set_count(2);
    push_entry(0, 1, 15, 1'b0);
    push_entry(1, 0, 0, 1'b0);
    push_entry(1, 1, 15, 1'b0);
    push_entry(0, 0, 0, 1'b1);
    // three vertices where the tree distance differs from the shortest path
    set_count(3);
    push_entry(0, 0, 0, 1'b0);
    push_entry(0, 1, 1, 1'b0);
    push_entry(0, 2, 9, 1'b0);
    push_entry(1, 0, 0, 1'b0);
    push_entry(1, 1, 0, 1'b0);
    push_entry(1, 2, 1, 1'b0);
    push_entry(2, 0, 0, 1'b0);
    push_entry(2, 1, 4, 1'b0);
    push_entry(2, 2, 0, 1'b1);

    // random: first full 16 x 16 load, then mixed sizes
    run_phase(16, 8);
    run_phase(5, 15);

    send_gap_pct = 45;
    recv_gap_pct = 11;
    run_phase(31, 8);               // saturates to the full vertex set
    run_phase(3, 20);
    run_phase(1, 10);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_phase(8, 18);
    run_phase(0, 5);
    run_phase(12, 8);

    wait_idle();
    repeat (EndDrain) @(posedge clk);
    if (expected_extents.size() != 0) begin
      $error("%0d results never arrived", expected_extents.size());
      failures++;
    end
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/grd_pkg.sv
rtl/core/grd_ram.sv
rtl/core/graph_radius_diameter_bfs.sv
test/tb_graph_radius_diameter_bfs.sv
